// File: design/sprcel_pkg.sv
// Shared types and constants for the sprite cel blitter.
package sprcel_pkg;

  // Upper limits of the priority bands; a baseline at or above all of them takes the fixed priority.
  localparam int unsigned BAND_COUNT = 11;
  localparam logic [7:0] BAND_LIMITS [BAND_COUNT] = '{
    8'd48, 8'd60, 8'd72, 8'd84, 8'd96, 8'd108, 8'd120, 8'd132, 8'd144, 8'd156, 8'd168
  };
  localparam int unsigned BAND_BASE = 4;

  // Default number of entries in the queue between the front and back ends.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    MODE_BEGIN = 1'b0,
    MODE_PIXEL = 1'b1
  } sprcel_mode_e;

  typedef struct packed {
    sprcel_mode_e mode;
    logic [7:0]   pos_x;
    logic [7:0]   pos_y;
    logic [7:0]   cel_width;
    logic [7:0]   cel_height;
    logic         mirror_flag;
    logic [7:0]   mirror_loop;
    logic [7:0]   loop_index;
    logic         auto_priority;
    logic [7:0]   fixed_priority;
    logic [7:0]   color_key;
    logic [7:0]   pixel_value;
  } sprcel_in_t;

  typedef struct packed {
    logic       write_enable;
    logic [8:0] dest_x;
    logic [7:0] dest_y;
    logic [7:0] color;
    logic [7:0] draw_priority;
    logic       end_of_cel;
  } sprcel_out_t;

  // Decoded beat passed from the front end to the back end.
  typedef struct packed {
    sprcel_mode_e mode;
    logic [7:0]   origin_x;
    logic [9:0]   top_row;
    logic [7:0]   width;
    logic [7:0]   height;
    logic         mirror_active;
    logic [7:0]   key;
    logic [7:0]   prio;
    logic [7:0]   pixel;
  } sprcel_cmd_t;

endpackage

// File: design/sprcel_front.sv
// Front end: decodes incoming beats into commands for the back end.
module sprcel_front (
  input  sprcel_pkg::sprcel_in_t  item_i,
  output sprcel_pkg::sprcel_cmd_t cmd_o
);
  import sprcel_pkg::*;

  logic [7:0] prio;

  // Priority band lookup when auto_priority is set: the lowest band whose limit exceeds the baseline wins.
  always_comb begin
    prio = item_i.fixed_priority;
    if (item_i.auto_priority) begin
      for (int i = BAND_COUNT - 1; i >= 0; i--) begin
        if (item_i.pos_y < BAND_LIMITS[i]) begin
          prio = 8'(BAND_BASE + i);
        end
      end
    end
  end

  always_comb begin
    cmd_o.mode          = item_i.mode;
    cmd_o.origin_x      = item_i.pos_x;
    cmd_o.top_row       = {2'b00, item_i.pos_y} + 10'd1 - {2'b00, item_i.cel_height};
    cmd_o.width         = item_i.cel_width;
    cmd_o.height        = item_i.cel_height;
    cmd_o.mirror_active = item_i.mirror_flag && (item_i.mirror_loop != item_i.loop_index);
    cmd_o.key           = item_i.color_key;
    cmd_o.prio          = prio;
    cmd_o.pixel         = item_i.pixel_value;
  end

endmodule

// File: design/sprcel_queue.sv
// Small command queue between the front and back ends.
module sprcel_queue #(
  parameter int unsigned Depth = sprcel_pkg::QUEUE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  sprcel_pkg::sprcel_cmd_t push_data_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output sprcel_pkg::sprcel_cmd_t pop_data_o,
  output logic                    empty_o
);
  import sprcel_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sprcel_cmd_t     entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/sprcel_back.sv
// Back end: holds the cel state, walks the pixels and registers the write requests.
module sprcel_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sprcel_pkg::sprcel_cmd_t cmd_i,
  input  logic                    cmd_avail_i,
  output logic                    cmd_take_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output sprcel_pkg::sprcel_out_t out_item_o
);
  import sprcel_pkg::*;

  logic [7:0]  origin_q, width_q, height_q, key_q, prio_q, col_q, row_q;
  logic [9:0]  top_q;
  logic        mirror_q, active_q;
  logic [7:0]  origin_d, width_d, height_d, key_d, prio_d, col_d, row_d;
  logic [9:0]  top_d;
  logic        mirror_d, active_d;
  logic        out_valid_q, out_valid_d;
  sprcel_out_t out_q, out_d;

  logic       do_begin, do_pixel, last;
  logic [7:0] col_sel;
  logic [9:0] yrow;
  logic [8:0] col_next;

  assign cmd_take_o = cmd_avail_i && (!out_valid_q || !out_stall_i);
  assign do_begin   = cmd_take_o && (cmd_i.mode == MODE_BEGIN);
  assign do_pixel   = cmd_take_o && (cmd_i.mode == MODE_PIXEL) && active_q;

  assign col_sel  = mirror_q ? (width_q - 8'd1 - col_q) : col_q;
  assign yrow     = top_q + {2'b00, row_q};
  assign col_next = {1'b0, col_q} + 9'd1;
  assign last     = (col_next == {1'b0, width_q})
                 && (({1'b0, row_q} + 9'd1) == {1'b0, height_q});

  always_comb begin
    origin_d = origin_q;
    width_d  = width_q;
    height_d = height_q;
    key_d    = key_q;
    prio_d   = prio_q;
    top_d    = top_q;
    mirror_d = mirror_q;
    col_d    = col_q;
    row_d    = row_q;
    active_d = active_q;
    out_d    = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (do_begin) begin
      origin_d = cmd_i.origin_x;
      width_d  = cmd_i.width;
      height_d = cmd_i.height;
      key_d    = cmd_i.key;
      prio_d   = cmd_i.prio;
      top_d    = cmd_i.top_row;
      mirror_d = cmd_i.mirror_active;
      col_d    = '0;
      row_d    = '0;
      active_d = (cmd_i.width != '0) && (cmd_i.height != '0);
    end else if (do_pixel) begin
      out_valid_d         = 1'b1;
      out_d.write_enable  = (cmd_i.pixel != key_q) && !yrow[9];
      out_d.dest_x        = {1'b0, origin_q} + {1'b0, col_sel};
      out_d.dest_y        = yrow[9] ? 8'd0 : yrow[7:0];
      out_d.color         = cmd_i.pixel;
      out_d.draw_priority = prio_q;
      out_d.end_of_cel    = last;
      if (col_next >= {1'b0, width_q}) begin
        col_d = '0;
        row_d = row_q + 8'd1;
      end else begin
        col_d = col_next[7:0];
      end
      if (last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q    <= '0;
      width_q     <= '0;
      height_q    <= '0;
      key_q       <= '0;
      prio_q      <= '0;
      top_q       <= '0;
      mirror_q    <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      origin_q    <= origin_d;
      width_q     <= width_d;
      height_q    <= height_d;
      key_q       <= key_d;
      prio_q      <= prio_d;
      top_q       <= top_d;
      mirror_q    <= mirror_d;
      col_q       <= col_d;
      row_q       <= row_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // An active cel always has a non-empty size.
  a_active_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (width_q != '0) && (height_q != '0))
    else $error("active cel with empty size");

  // The column counter stays inside the cel row while a cel is drawn.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (col_q < width_q))
    else $error("column counter beyond cel width");

  // The last pixel closes the cel.
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pixel && last) |=> !active_q)
    else $error("cel still active after its last pixel");

endmodule

// File: design/sprite_cel_blitter_core.sv
// Top level of the sprite cel blitter: front end, command queue and back end.
//
// Usage: beats arrive on the input channel (in_valid_i, in_stall_o, in_item_i).
// A begin beat (mode MODE_BEGIN) loads a cel's origin, size, mirroring, colour key
// and draw priority; the priority band lookup is done as the beat is accepted.
// Pixel beats (mode MODE_PIXEL) then follow in row-major order, and each one
// yields one write request on the output channel (out_valid_o, out_stall_i,
// out_item_o). Begin beats, and pixel beats arriving with no cel in progress,
// yield nothing. A begin beat during a cel abandons that cel.
// A pixel accepted on the input is written into the queue; the back end pops it
// and registers its write request in the output register, from which it is offered.
// Throughput: one beat per cycle while the output is not stalled; the back end
// walks one pixel per cycle through its column and row counters.
// The queue between the front and back ends lets the input keep flowing while
// the receiver stalls; once it is full, in_stall_o is raised.
// A stalled request is held unchanged in the output register.
// Reset clears the queue, the cel state and the output valid; no cel is active.
module sprite_cel_blitter_core #(
  parameter int unsigned QueueDepth = sprcel_pkg::QUEUE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  sprcel_pkg::sprcel_in_t  in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output sprcel_pkg::sprcel_out_t out_item_o
);
  import sprcel_pkg::*;

  sprcel_cmd_t front_cmd;
  sprcel_cmd_t queue_cmd;
  logic        queue_full;
  logic        queue_empty;
  logic        back_take;

  // The front end decodes each beat as it is accepted.
  sprcel_front u_front (
    .item_i (in_item_i),
    .cmd_o  (front_cmd)
  );

  // The input is stalled only while the queue is full.
  assign in_stall_o = queue_full;

  sprcel_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (back_take),
    .pop_data_o  (queue_cmd),
    .empty_o     (queue_empty)
  );

  // The back end takes a command whenever its output register is free or draining.
  sprcel_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_avail_i (!queue_empty),
    .cmd_take_o  (back_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
